[rtl/jtp_pkg.sv]
// ============================================================================
// jtp_pkg - shared types and codes for the Johnson-Trotter permuter
// Entry layout, command and status codes, scan control group.
// ============================================================================
package jtp_pkg;

    localparam int VALUE_W  = 16;
    localparam int POS_W    = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_STEP   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DONE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // dir = 1 points left
    typedef struct packed {
        logic                      dir;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    // control for one mobility evaluation
    typedef struct packed {
        logic start;
        logic en;
        logic has_left;
        logic has_right;
    } scan_ctl_t;

endpackage

[rtl/jtp_store.sv]
// ============================================================================
// jtp_store - element store
// Single write port, single read port, registered read data.
// Read data holds until the next read is issued.
// ============================================================================
module jtp_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  jtp_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output jtp_pkg::entry_t rd_data
);

    jtp_pkg::entry_t mem_reg [DEPTH];
    jtp_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/jtp_scan.sv]
// ============================================================================
// jtp_scan - largest mobile element tracker
// Evaluates one element per cycle, when enabled, against its neighbors and keeps the
// largest mobile one seen so far together with its swap partner.
// ============================================================================
module jtp_scan #(
    parameter int IDX_W = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  jtp_pkg::scan_ctl_t  ctl,
    input  logic [IDX_W-1:0]    idx,
    input  jtp_pkg::entry_t     left,
    input  jtp_pkg::entry_t     center,
    input  jtp_pkg::entry_t     right,
    output logic                found,
    output logic                found_next,
    output logic [IDX_W-1:0]    best_idx,
    output logic [IDX_W-1:0]    tgt_idx,
    output jtp_pkg::entry_t     best_entry,
    output jtp_pkg::entry_t     tgt_entry
);

    logic            found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] tgt_idx_reg;
    jtp_pkg::entry_t best_entry_reg;
    jtp_pkg::entry_t tgt_entry_reg;

    logic mob_left;
    logic mob_right;
    logic take;

    assign mob_left  = center.dir && ctl.has_left &&
                       ($signed(left.value) < $signed(center.value));
    assign mob_right = !center.dir && ctl.has_right &&
                       ($signed(right.value) < $signed(center.value));

    // strict compare: lowest position wins among equal values
    assign take = ctl.en && (mob_left || mob_right) &&
                  (!found_reg || ($signed(center.value) > $signed(best_entry_reg.value)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg   <= idx;
            best_entry_reg <= center;
            tgt_idx_reg    <= mob_left ? idx - 1'b1 : idx + 1'b1;
            tgt_entry_reg  <= mob_left ? left : right;
        end
    end

    assign found      = found_reg;
    assign found_next = found_reg || take;
    assign best_idx   = best_idx_reg;
    assign tgt_idx    = tgt_idx_reg;
    assign best_entry = best_entry_reg;
    assign tgt_entry  = tgt_entry_reg;

endmodule

[rtl/johnson_trotter_permuter_unit.sv]
// ============================================================================
// johnson_trotter_permuter_unit - Johnson-Trotter permutation generator
// Command-driven store of signed values that steps through permutations.
// ============================================================================
// Clear and append complete in the idle state; an append returns one beat.
// A step over n stored elements first sweeps the store through its single
// read port (scan state, then a tail state for the last element) to find
// the largest mobile element, then sends one beat per cycle, while the
// output is not stalled, as the swapped and direction-updated arrangement
// is written back and sent out, positions 0..n-1 with tlast on the final
// one. A new beat is taken only once the previous command is finished and
// the output register is free. Steps on an empty store or with no mobile
// element give a single status beat.
module johnson_trotter_permuter_unit #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] element_value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] out_value, [19:16] out_position, rest 0
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int POS_W = jtp_pkg::POS_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_TAIL = 5'b00100,
        S_EMIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ai_reg, ai_next;
    logic             arr_vld_reg, arr_vld_next;
    logic [IDX_W-1:0] arr_idx_reg, arr_idx_next;
    logic [IDX_W-1:0] ei_reg, ei_next;
    jtp_pkg::entry_t  w0_reg, w0_next;
    jtp_pkg::entry_t  w1_reg, w1_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [jtp_pkg::VALUE_W-1:0]   m_value_reg, m_value_next;
    logic [POS_W-1:0]              m_pos_reg, m_pos_next;
    logic                          m_last_reg, m_last_next;
    jtp_pkg::status_t              m_status_reg, m_status_next;

    logic             slot_free;
    logic             in_fire;
    jtp_pkg::op_t     op;
    logic [IDX_W-1:0] last_idx;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    jtp_pkg::entry_t  wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    jtp_pkg::entry_t  rd_data;

    jtp_pkg::scan_ctl_t sc_ctl;
    logic [IDX_W-1:0]   sc_idx;
    logic               sc_found;
    logic               sc_found_next;
    logic [IDX_W-1:0]   sc_best_idx;
    logic [IDX_W-1:0]   sc_tgt_idx;
    jtp_pkg::entry_t    sc_best_entry;
    jtp_pkg::entry_t    sc_tgt_entry;

    jtp_pkg::entry_t  em_in;
    jtp_pkg::entry_t  em_out;

    jtp_store #(
        .DEPTH (MAX_ELEMENTS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    jtp_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (sc_ctl),
        .idx        (sc_idx),
        .left       (w0_reg),
        .center     (w1_reg),
        .right      (rd_data),
        .found      (sc_found),
        .found_next (sc_found_next),
        .best_idx   (sc_best_idx),
        .tgt_idx    (sc_tgt_idx),
        .best_entry (sc_best_entry),
        .tgt_entry  (sc_tgt_entry)
    );

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign in_fire   = s_tvalid && s_tready;
    assign op        = jtp_pkg::op_t'(s_tuser);
    assign last_idx  = IDX_W'(cnt_reg - 1'b1);

    // swap applied on the fly, then flip everything larger than the mover
    always_comb begin
        em_in = rd_data;
        if (ei_reg == sc_best_idx) begin
            em_in = sc_tgt_entry;
        end else if (ei_reg == sc_tgt_idx) begin
            em_in = sc_best_entry;
        end
        em_out = em_in;
        if ($signed(em_in.value) > $signed(sc_best_entry.value)) begin
            em_out.dir = !em_in.dir;
        end
    end

    // scan evaluates element k-1 when entry k arrives; the tail cycle
    // handles the last element with no right neighbor
    always_comb begin
        sc_ctl           = '0;
        sc_idx           = arr_idx_reg - 1'b1;
        sc_ctl.start     = in_fire && (op == jtp_pkg::OP_STEP);
        if (state_reg == S_SCAN) begin
            sc_ctl.en        = arr_vld_reg && (arr_idx_reg != '0);
            sc_ctl.has_left  = (sc_idx != '0);
            sc_ctl.has_right = 1'b1;
        end else if (state_reg == S_TAIL) begin
            sc_idx           = last_idx;
            sc_ctl.en        = 1'b1;
            sc_ctl.has_left  = (last_idx != '0);
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ai_next       = ai_reg;
        arr_vld_next  = 1'b0;
        arr_idx_next  = arr_idx_reg;
        ei_next       = ei_reg;
        w0_next       = w0_reg;
        w1_next       = w1_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_pos_next    = m_pos_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;
        wr_en         = 1'b0;
        wr_addr       = ei_reg;
        wr_data       = em_out;
        rd_en         = 1'b0;
        rd_addr       = ai_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (op)
                        jtp_pkg::OP_CLEAR: begin
                            cnt_next = '0;
                        end
                        jtp_pkg::OP_APPEND: begin
                            m_tvalid_next = 1'b1;
                            m_last_next   = 1'b1;
                            if (cnt_reg == CNT_W'(MAX_ELEMENTS)) begin
                                m_value_next  = '0;
                                m_pos_next    = '0;
                                m_status_next = jtp_pkg::ST_FULL;
                            end else begin
                                wr_en         = 1'b1;
                                wr_addr       = cnt_reg[IDX_W-1:0];
                                wr_data.dir   = 1'b1;
                                wr_data.value = s_tdata;
                                m_value_next  = s_tdata;
                                m_pos_next    = POS_W'(cnt_reg);
                                m_status_next = jtp_pkg::ST_OK;
                                cnt_next      = cnt_reg + 1'b1;
                            end
                        end
                        jtp_pkg::OP_STEP: begin
                            if (cnt_reg == '0) begin
                                m_tvalid_next = 1'b1;
                                m_last_next   = 1'b1;
                                m_value_next  = '0;
                                m_pos_next    = '0;
                                m_status_next = jtp_pkg::ST_EMPTY;
                            end else begin
                                ai_next    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        jtp_pkg::OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (ai_reg < cnt_reg) begin
                    rd_en        = 1'b1;
                    ai_next      = ai_reg + 1'b1;
                    arr_vld_next = 1'b1;
                    arr_idx_next = ai_reg[IDX_W-1:0];
                end
                if (arr_vld_reg) begin
                    w0_next = w1_reg;
                    w1_next = rd_data;
                    if (arr_idx_reg == last_idx) begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ei_next = '0;
                state_next = sc_found_next ? S_EMIT : S_DONE;
            end
            S_EMIT: begin
                if (slot_free) begin
                    wr_en         = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_value_next  = em_out.value;
                    m_pos_next    = POS_W'(ei_reg);
                    m_last_next   = (ei_reg == last_idx);
                    m_status_next = jtp_pkg::ST_OK;
                    if (ei_reg == last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ei_reg + 1'b1;
                        ei_next = ei_reg + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_last_next   = 1'b1;
                    m_value_next  = '0;
                    m_pos_next    = '0;
                    m_status_next = jtp_pkg::ST_DONE;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ai_reg       <= '0;
            arr_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ai_reg       <= ai_next;
            arr_vld_reg  <= arr_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        arr_idx_reg  <= arr_idx_next;
        ei_reg       <= ei_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        m_value_reg  <= m_value_next;
        m_pos_reg    <= m_pos_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_pos_reg, m_value_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("store read and write hit the same entry");

    a_emit_has_mover: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> sc_found)
        else $error("emitting without a mobile element");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != jtp_pkg::ST_OK)) |-> m_tlast)
        else $error("status beat not marked last");

endmodule

[test/tb_johnson_trotter_permuter_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_johnson_trotter_permuter_unit - command stream test of the permuter
// Drives clear/append/step commands with random gaps and output stalls,
// predicts every output beat from its own copy of the store and directions,
// and checks each beat field by field in order.
// ============================================================================
module tb_johnson_trotter_permuter_unit;

    localparam int MAX_ELEMENTS = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 270;

    typedef struct {
        logic [jtp_pkg::VALUE_W-1:0] value;
        logic [jtp_pkg::POS_W-1:0]   position;
        logic                        last;
        jtp_pkg::status_t            status;
    } perm_beat_t;

    // tracks the arrangement and the beats it must produce
    class permutation_scoreboard;
        logic signed [jtp_pkg::VALUE_W-1:0] slot_value [MAX_ELEMENTS];
        logic                               slot_left  [MAX_ELEMENTS];
        int                                 fill;
        perm_beat_t                         awaited [$];
        int                                 errors;
        int                                 beat_no;

        function new();
            fill    = 0;
            errors  = 0;
            beat_no = 0;
        endfunction

        function void push_beat(logic [jtp_pkg::VALUE_W-1:0] v, int pos, logic last,
                                jtp_pkg::status_t st);
            perm_beat_t b;
            b.value    = v;
            b.position = jtp_pkg::POS_W'(pos);
            b.last     = last;
            b.status   = st;
            awaited.push_back(b);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_command(jtp_pkg::op_t op, logic [jtp_pkg::VALUE_W-1:0] v);
            int best, target, t;
            logic signed [jtp_pkg::VALUE_W-1:0] moved;
            logic hold_d;
            best   = -1;
            target = -1;
            case (op)
                jtp_pkg::OP_CLEAR: fill = 0;
                jtp_pkg::OP_APPEND: begin
                    if (fill >= MAX_ELEMENTS) begin
                        push_beat('0, 0, 1'b1, jtp_pkg::ST_FULL);
                    end else begin
                        slot_value[fill] = v;
                        slot_left[fill]  = 1'b1;
                        push_beat(v, fill, 1'b1, jtp_pkg::ST_OK);
                        fill++;
                    end
                end
                jtp_pkg::OP_STEP: begin
                    if (fill == 0) begin
                        push_beat('0, 0, 1'b1, jtp_pkg::ST_EMPTY);
                        return;
                    end
                    for (int i = 0; i < fill; i++) begin
                        t = -1;
                        if (slot_left[i]) begin
                            if (i > 0 && slot_value[i-1] < slot_value[i]) t = i - 1;
                        end else begin
                            if (i + 1 < fill && slot_value[i+1] < slot_value[i]) t = i + 1;
                        end
                        // strict compare keeps the lowest position among equal values
                        if (t >= 0 && (best < 0 || slot_value[i] > slot_value[best])) begin
                            best   = i;
                            target = t;
                        end
                    end
                    if (best < 0) begin
                        push_beat('0, 0, 1'b1, jtp_pkg::ST_DONE);
                        return;
                    end
                    moved              = slot_value[best];
                    hold_d             = slot_left[best];
                    slot_value[best]   = slot_value[target];
                    slot_left[best]    = slot_left[target];
                    slot_value[target] = moved;
                    slot_left[target]  = hold_d;
                    for (int i = 0; i < fill; i++)
                        if (slot_value[i] > moved) slot_left[i] = !slot_left[i];
                    for (int i = 0; i < fill; i++)
                        push_beat(slot_value[i], i, (i + 1 == fill), jtp_pkg::ST_OK);
                end
                default: ;
            endcase
        endfunction

        task report(string field, logic [jtp_pkg::VALUE_W-1:0] want,
                    logic [jtp_pkg::VALUE_W-1:0] got);
            $display("mismatch at beat %0d, %s: expected %h, got %h", beat_no, field, want, got);
            errors++;
        endtask

        task check_beat(logic [23:0] data, logic last, logic [jtp_pkg::STATUS_W-1:0] status);
            perm_beat_t b;
            if (awaited.size() == 0) begin
                report("unexpected beat", '0, data[15:0]);
            end else begin
                b = awaited.pop_front();
                if (data[15:0] !== b.value) report("value", b.value, data[15:0]);
                if (data[19:16] !== b.position) report("position", b.position, data[19:16]);
                if (data[23:20] !== 4'd0) report("tdata pad", '0, data[23:20]);
                if (last !== b.last) report("tlast", b.last, last);
                if (status !== b.status) report("status", b.status, status);
            end
            beat_no++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = jtp_pkg::OP_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    permutation_scoreboard sb = new();
    int  cycles       = 0;
    int  issued       = 0;
    bit  send_burst   = 1'b0;

    johnson_trotter_permuter_unit #(.MAX_ELEMENTS(MAX_ELEMENTS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one command beat; returns after the handshake edge
    task automatic issue(input jtp_pkg::op_t op, input logic [15:0] v);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_command(op, v);
        issued++;
    endtask

    function automatic logic [15:0] draw_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3));
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic issue_noise();
        issue(jtp_pkg::op_t'($urandom_range(0, 3)), 16'($urandom()));
    endtask

    // clear, load k elements, then walk through some permutations
    task automatic run_sequence();
        int k, steps;
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_ELEMENTS)
                                        : $urandom_range(2, 5);
        if (k > 5) steps = $urandom_range(1, 3);
        else if (k == 2) steps = $urandom_range(1, 4);
        else if (k == 3) steps = $urandom_range(1, 8);
        else steps = $urandom_range(4, 26);
        issue(jtp_pkg::OP_CLEAR, 16'($urandom()));
        for (int i = 0; i < k; i++) begin
            issue(jtp_pkg::OP_APPEND, draw_value());
            if ($urandom_range(0, 24) == 0) issue_noise();
        end
        if (k == MAX_ELEMENTS) issue(jtp_pkg::OP_APPEND, draw_value());
        for (int i = 0; i < steps; i++) begin
            issue(jtp_pkg::OP_STEP, 16'($urandom()));
            if ($urandom_range(0, 11) == 0) issue_noise();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty step, ignored opcode, single element, extremes
        issue(jtp_pkg::OP_STEP, 16'h1234);
        issue(jtp_pkg::OP_NONE, 16'hFFFF);
        issue(jtp_pkg::OP_APPEND, 16'h7FFF);
        issue(jtp_pkg::OP_STEP, 16'h0000);
        issue(jtp_pkg::OP_APPEND, 16'h8000);
        issue(jtp_pkg::OP_APPEND, 16'h0000);
        issue(jtp_pkg::OP_STEP, 16'hFFFF);
        issue(jtp_pkg::OP_STEP, 16'h5A5A);
        issue(jtp_pkg::OP_CLEAR, 16'hFFFF);
        // two equal mobile maxima: the lower position must move
        issue(jtp_pkg::OP_APPEND, 16'd1);
        issue(jtp_pkg::OP_APPEND, 16'd7);
        issue(jtp_pkg::OP_APPEND, 16'd2);
        issue(jtp_pkg::OP_APPEND, 16'd7);
        issue(jtp_pkg::OP_STEP, 16'h0000);
        issue(jtp_pkg::OP_STEP, 16'h0000);
        issue(jtp_pkg::OP_CLEAR, 16'h0000);
        // fill to capacity, then overflow
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            case (i)
                0: issue(jtp_pkg::OP_APPEND, 16'h8000);
                1: issue(jtp_pkg::OP_APPEND, 16'h7FFF);
                2: issue(jtp_pkg::OP_APPEND, 16'hFFFF);
                default: issue(jtp_pkg::OP_APPEND, 16'(i * 997 - 5000));
            endcase
        end
        issue(jtp_pkg::OP_APPEND, 16'h4321);
        issue(jtp_pkg::OP_STEP, 16'h0000);
        issue(jtp_pkg::OP_CLEAR, 16'h0000);

        while (issued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) issue_noise();
            end else begin
                run_sequence();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result sink with random stalls and one long hold-off
    initial begin
        int  gap;
        int  beats;
        bit  burst;
        bit  held;
        beats = 0;
        burst = 1'b0;
        held  = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 19) == 0) burst = !burst;
            if (!held && beats >= 100) begin
                held = 1'b1;
                gap  = 300;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_beat(m_tdata, m_tlast, m_tuser);
            beats++;
        end
    end

endmodule

[files.f]
rtl/jtp_pkg.sv
rtl/jtp_store.sv
rtl/jtp_scan.sv
rtl/johnson_trotter_permuter_unit.sv
test/tb_johnson_trotter_permuter_unit.sv
